// ===== hw/rtl/pbtp_pkg.sv =====
// ----------------------------------------------------------------------------
// pbtp_pkg
// Types and constants for the plain bitmap text parser: phase codes, input
// item kinds, result kinds, error codes, character codes and the result record.
// ----------------------------------------------------------------------------
package pbtp_pkg;

  // Parser phase
  typedef enum logic [3:0] {
    PH_MAGIC0,
    PH_MAGIC1,
    PH_MAGIC2,
    PH_BLANK1,
    PH_WIDTH,
    PH_HEIGHT,
    PH_BLANK2,
    PH_PIXELS,
    PH_DONE,
    PH_ERROR
  } phase_t;

  // Input item kinds (code 3 is unused and ignored)
  localparam logic [1:0] KIND_DATA    = 2'd0;
  localparam logic [1:0] KIND_EOF     = 2'd1;
  localparam logic [1:0] KIND_RESTART = 2'd2;

  // Result kinds
  localparam logic [1:0] RES_HEADER = 2'd0;
  localparam logic [1:0] RES_PIXEL  = 2'd1;
  localparam logic [1:0] RES_ERROR  = 2'd2;

  // Error codes
  localparam logic [1:0] ERR_MAGIC     = 2'd0;
  localparam logic [1:0] ERR_HEADER    = 2'd1;
  localparam logic [1:0] ERR_PREMATURE = 2'd2;
  localparam logic [1:0] ERR_DATA      = 2'd3;

  // Character codes
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // One result item as held in the output queue
  typedef struct packed {
    logic [1:0]  result_kind;
    logic        pixel;
    logic [15:0] width;
    logic [15:0] height;
    logic [15:0] row;
    logic [15:0] column;
    logic [1:0]  error_code;
    logic        image_done;
    logic        last;
  } result_t;

endpackage

// ===== hw/rtl/plain_bitmap_text_parser.sv =====
// ----------------------------------------------------------------------------
// plain_bitmap_text_parser
// Byte-serial parser for plain-text (P1) bitmaps: magic check, header with
// comments, decimal dimensions, then one result per pixel in row-major order.
// ----------------------------------------------------------------------------
// The block takes one item (data byte, end-of-input mark or restart) per clock
// while the result side takes each result as it comes, and turns out results
// through a two-entry output queue. The single item that ends the height and
// produces both a header and an error holds in_stall high after it while the
// queue drains, since an item is taken only when both queue entries are free
// after this cycle's read. Dimensions are checked against 2**DIM_BITS - 1;
// width, height, row and column leave on 16-bit ports with their low 16 bits.
// After image completion or an error, items are dropped until a restart item
// arrives.
module plain_bitmap_text_parser #(
  parameter int DIM_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_kind,
  input  logic [7:0]  in_byte_req,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_result_kind,
  output logic        out_pixel,
  output logic [15:0] out_width,
  output logic [15:0] out_height,
  output logic [15:0] out_row,
  output logic [15:0] out_column,
  output logic [1:0]  out_error_code,
  output logic        out_image_done,
  output logic        out_last
);

  localparam int ACC_W = DIM_BITS + 4;
  localparam logic [ACC_W-1:0] DIM_MAX = {4'b0, {DIM_BITS{1'b1}}};

  // Parser state
  pbtp_pkg::phase_t    phase_r, phase_nxt;
  logic                in_comment_r, in_comment_nxt;
  logic [DIM_BITS-1:0] acc_r, acc_nxt;
  logic                saw_digit_r, saw_digit_nxt;
  logic [DIM_BITS-1:0] width_r, width_nxt;
  logic [DIM_BITS-1:0] height_r, height_nxt;
  logic [DIM_BITS-1:0] row_r, row_nxt;
  logic [DIM_BITS-1:0] col_r, col_nxt;

  // Output queue: slot 0 is the head
  pbtp_pkg::result_t   slot_r [2];
  pbtp_pkg::result_t   slot_nxt [2];
  logic [1:0]          count_r, count_nxt;

  logic                in_acc;
  logic                out_pop;

  // Byte classes
  logic                is_eof;
  logic                is_ws;
  logic                is_digit;
  logic                is_bit;
  logic                is_eol;

  // Digit accumulate
  logic [ACC_W-1:0]    acc_ext;
  logic [ACC_W-1:0]    acc_sum;
  logic                acc_over;

  // Pixel position advance
  logic [DIM_BITS:0]   col_inc;
  logic [DIM_BITS:0]   row_inc;

  // Result requests for this item
  logic                hdr_req;
  logic                hdr_done;
  logic                err_req;
  logic [1:0]          err_code;
  logic                pix_req;
  logic                pix_done;
  pbtp_pkg::result_t   res0, res1;
  logic [1:0]          res_n;

  // Zero-extended copies used to truncate to the 16-bit ports
  logic [DIM_BITS+15:0] width_ext, height_ext, row_ext, col_ext;

  assign out_pop  = out_valid && !out_stall;
  assign in_stall = !((count_r == 2'd0) || ((count_r == 2'd1) && out_pop));
  assign in_acc   = in_valid && !in_stall;

  // Classify the incoming byte
  assign is_eof   = (in_kind == pbtp_pkg::KIND_EOF);
  assign is_ws    = (in_byte_req == pbtp_pkg::CH_SPACE) ||
                    ((in_byte_req >= pbtp_pkg::CH_TAB) && (in_byte_req <= pbtp_pkg::CH_CR));
  assign is_digit = (in_byte_req >= pbtp_pkg::CH_ZERO) && (in_byte_req <= pbtp_pkg::CH_NINE);
  assign is_bit   = (in_byte_req == pbtp_pkg::CH_ZERO) || (in_byte_req == pbtp_pkg::CH_ONE);
  assign is_eol   = (in_byte_req == pbtp_pkg::CH_LF) || (in_byte_req == pbtp_pkg::CH_CR);

  // Accumulate one decimal digit: acc * 10 + d, flag overflow
  assign acc_ext  = {4'b0, acc_r};
  assign acc_sum  = (acc_ext << 3) + (acc_ext << 1) +
                    {{(ACC_W-4){1'b0}}, in_byte_req[3:0]};
  assign acc_over = (acc_sum > DIM_MAX);

  // Advance the pixel position
  assign col_inc  = {1'b0, col_r} + {{DIM_BITS{1'b0}}, 1'b1};
  assign row_inc  = {1'b0, row_r} + {{DIM_BITS{1'b0}}, 1'b1};

  // The header carries the height that is still in the accumulator
  assign width_ext  = {16'b0, width_r};
  assign height_ext = {16'b0, acc_r};
  assign row_ext    = {16'b0, row_r};
  assign col_ext    = {16'b0, col_r};

  // Next parser state and result requests
  always_comb begin
    phase_nxt      = phase_r;
    in_comment_nxt = in_comment_r;
    acc_nxt        = acc_r;
    saw_digit_nxt  = saw_digit_r;
    width_nxt      = width_r;
    height_nxt     = height_r;
    row_nxt        = row_r;
    col_nxt        = col_r;
    hdr_req        = 1'b0;
    hdr_done       = 1'b0;
    err_req        = 1'b0;
    err_code       = pbtp_pkg::ERR_MAGIC;
    pix_req        = 1'b0;
    pix_done       = 1'b0;

    if (in_acc) begin
      if (in_kind == pbtp_pkg::KIND_RESTART) begin
        phase_nxt      = pbtp_pkg::PH_MAGIC0;
        in_comment_nxt = 1'b0;
        acc_nxt        = '0;
        saw_digit_nxt  = 1'b0;
        width_nxt      = '0;
        height_nxt     = '0;
        row_nxt        = '0;
        col_nxt        = '0;
      end else if ((in_kind == pbtp_pkg::KIND_DATA) || is_eof) begin
        case (phase_r)
          pbtp_pkg::PH_MAGIC0: begin
            if (!is_eof && (in_byte_req == pbtp_pkg::CH_P)) begin
              phase_nxt = pbtp_pkg::PH_MAGIC1;
            end else begin
              err_req  = 1'b1;
              err_code = pbtp_pkg::ERR_MAGIC;
            end
          end
          pbtp_pkg::PH_MAGIC1: begin
            if (!is_eof && (in_byte_req == pbtp_pkg::CH_ONE)) begin
              phase_nxt = pbtp_pkg::PH_MAGIC2;
            end else begin
              err_req  = 1'b1;
              err_code = pbtp_pkg::ERR_MAGIC;
            end
          end
          pbtp_pkg::PH_MAGIC2: begin
            if (!is_eof && is_ws) begin
              phase_nxt = pbtp_pkg::PH_BLANK1;
            end else begin
              err_req  = 1'b1;
              err_code = pbtp_pkg::ERR_MAGIC;
            end
          end
          pbtp_pkg::PH_BLANK1, pbtp_pkg::PH_BLANK2: begin
            if (is_eof) begin
              err_req  = 1'b1;
              err_code = (phase_r == pbtp_pkg::PH_BLANK1) ? pbtp_pkg::ERR_HEADER
                                                          : pbtp_pkg::ERR_PREMATURE;
            end else if (in_comment_r) begin
              if (is_eol) begin
                in_comment_nxt = 1'b0;
              end
            end else if (is_ws) begin
              // skip whitespace
            end else if (in_byte_req == pbtp_pkg::CH_HASH) begin
              in_comment_nxt = 1'b1;
            end else if (phase_r == pbtp_pkg::PH_BLANK1) begin
              if (is_digit) begin
                acc_nxt       = {{(DIM_BITS-4){1'b0}}, in_byte_req[3:0]};
                saw_digit_nxt = 1'b1;
                phase_nxt     = pbtp_pkg::PH_WIDTH;
              end else begin
                err_req  = 1'b1;
                err_code = pbtp_pkg::ERR_HEADER;
              end
            end else if (is_bit) begin
              pix_req = 1'b1;
            end else begin
              err_req  = 1'b1;
              err_code = pbtp_pkg::ERR_DATA;
            end
          end
          pbtp_pkg::PH_WIDTH: begin
            if (is_eof) begin
              err_req  = 1'b1;
              err_code = pbtp_pkg::ERR_HEADER;
            end else if (is_digit) begin
              acc_nxt = acc_sum[DIM_BITS-1:0];
              if (acc_over) begin
                err_req  = 1'b1;
                err_code = pbtp_pkg::ERR_HEADER;
              end
            end else if (is_ws) begin
              width_nxt     = acc_r;
              acc_nxt       = '0;
              saw_digit_nxt = 1'b0;
              phase_nxt     = pbtp_pkg::PH_HEIGHT;
            end else begin
              err_req  = 1'b1;
              err_code = pbtp_pkg::ERR_HEADER;
            end
          end
          pbtp_pkg::PH_HEIGHT: begin
            if (!saw_digit_r) begin
              if (is_eof) begin
                err_req  = 1'b1;
                err_code = pbtp_pkg::ERR_HEADER;
              end else if (is_ws) begin
                // skip whitespace
              end else if (is_digit) begin
                acc_nxt       = {{(DIM_BITS-4){1'b0}}, in_byte_req[3:0]};
                saw_digit_nxt = 1'b1;
              end else begin
                err_req  = 1'b1;
                err_code = pbtp_pkg::ERR_HEADER;
              end
            end else if (!is_eof && is_digit) begin
              acc_nxt = acc_sum[DIM_BITS-1:0];
              if (acc_over) begin
                err_req  = 1'b1;
                err_code = pbtp_pkg::ERR_HEADER;
              end
            end else begin
              // Height complete: emit header, then decide what follows
              height_nxt    = acc_r;
              acc_nxt       = '0;
              saw_digit_nxt = 1'b0;
              hdr_req       = 1'b1;
              hdr_done      = (width_r == '0) || (acc_r == '0);
              if (hdr_done) begin
                phase_nxt = pbtp_pkg::PH_DONE;
              end else if (is_eof) begin
                err_req  = 1'b1;
                err_code = pbtp_pkg::ERR_PREMATURE;
              end else if (is_ws) begin
                phase_nxt = pbtp_pkg::PH_BLANK2;
              end else if (in_byte_req == pbtp_pkg::CH_HASH) begin
                in_comment_nxt = 1'b1;
                phase_nxt      = pbtp_pkg::PH_BLANK2;
              end else begin
                err_req  = 1'b1;
                err_code = pbtp_pkg::ERR_DATA;
              end
            end
          end
          pbtp_pkg::PH_PIXELS: begin
            if (is_eof) begin
              err_req  = 1'b1;
              err_code = pbtp_pkg::ERR_PREMATURE;
            end else if (is_ws) begin
              // skip whitespace
            end else if (is_bit) begin
              pix_req = 1'b1;
            end else begin
              err_req  = 1'b1;
              err_code = pbtp_pkg::ERR_DATA;
            end
          end
          default: begin
            // finished or failed: drop the item
          end
        endcase

        // Step the pixel position
        if (pix_req) begin
          phase_nxt = pbtp_pkg::PH_PIXELS;
          col_nxt   = col_inc[DIM_BITS-1:0];
          if (col_inc >= {1'b0, width_r}) begin
            col_nxt = '0;
            row_nxt = row_inc[DIM_BITS-1:0];
            if (row_inc >= {1'b0, height_r}) begin
              pix_done  = 1'b1;
              phase_nxt = pbtp_pkg::PH_DONE;
            end
          end
        end

        if (err_req) begin
          phase_nxt = pbtp_pkg::PH_ERROR;
        end
      end
    end
  end

  // Build the result items for this input item
  always_comb begin
    pbtp_pkg::result_t hdr_res, err_res, pix_res;

    hdr_res             = '0;
    hdr_res.result_kind = pbtp_pkg::RES_HEADER;
    hdr_res.width       = width_ext[15:0];
    hdr_res.height      = height_ext[15:0];
    hdr_res.image_done  = hdr_done;

    err_res             = '0;
    err_res.result_kind = pbtp_pkg::RES_ERROR;
    err_res.error_code  = err_code;

    pix_res             = '0;
    pix_res.result_kind = pbtp_pkg::RES_PIXEL;
    pix_res.pixel       = in_byte_req[0];
    pix_res.row         = row_ext[15:0];
    pix_res.column      = col_ext[15:0];
    pix_res.image_done  = pix_done;

    res0  = '0;
    res1  = '0;
    res_n = 2'd0;
    if (hdr_req && err_req) begin
      res0      = hdr_res;
      res1      = err_res;
      res1.last = 1'b1;
      res_n     = 2'd2;
    end else if (hdr_req) begin
      res0      = hdr_res;
      res0.last = 1'b1;
      res_n     = 2'd1;
    end else if (err_req) begin
      res0      = err_res;
      res0.last = 1'b1;
      res_n     = 2'd1;
    end else if (pix_req) begin
      res0      = pix_res;
      res0.last = 1'b1;
      res_n     = 2'd1;
    end
  end

  // Advance the output queue: pop the head, then append this item's results
  always_comb begin
    slot_nxt[0] = slot_r[0];
    slot_nxt[1] = slot_r[1];
    if (out_pop) begin
      slot_nxt[0] = slot_r[1];
    end
    // an item is taken only when the queue is empty after the pop
    if (res_n != 2'd0) begin
      slot_nxt[0] = res0;
      slot_nxt[1] = res1;
    end
    count_nxt = count_r - {1'b0, out_pop} + res_n;
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= pbtp_pkg::PH_MAGIC0;
      in_comment_r <= 1'b0;
      acc_r        <= '0;
      saw_digit_r  <= 1'b0;
      width_r      <= '0;
      height_r     <= '0;
      row_r        <= '0;
      col_r        <= '0;
      count_r      <= 2'd0;
    end else begin
      phase_r      <= phase_nxt;
      in_comment_r <= in_comment_nxt;
      acc_r        <= acc_nxt;
      saw_digit_r  <= saw_digit_nxt;
      width_r      <= width_nxt;
      height_r     <= height_nxt;
      row_r        <= row_nxt;
      col_r        <= col_nxt;
      count_r      <= count_nxt;
    end
  end

  // Queue payload, no reset
  always_ff @(posedge clk) begin
    slot_r[0] <= slot_nxt[0];
    slot_r[1] <= slot_nxt[1];
  end

  // Drive the result ports from the queue head
  assign out_valid       = (count_r != 2'd0);
  assign out_result_kind = slot_r[0].result_kind;
  assign out_pixel       = slot_r[0].pixel;
  assign out_width       = slot_r[0].width;
  assign out_height      = slot_r[0].height;
  assign out_row         = slot_r[0].row;
  assign out_column      = slot_r[0].column;
  assign out_error_code  = slot_r[0].error_code;
  assign out_image_done  = slot_r[0].image_done;
  assign out_last        = slot_r[0].last;

  // Queue never holds more than two results
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != 2'd3)
    else $error("result queue overfilled");

  // An item is taken only when the queue is empty after this cycle's read
  a_accept_room: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> (count_r == 2'd0) || ((count_r == 2'd1) && out_pop))
    else $error("item taken without queue room");

  // With two results queued, only the second one closes the item
  a_pair_last: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == 2'd2) |-> (slot_r[1].last && !slot_r[0].last))
    else $error("last flag misplaced in result pair");

  // A finished or failed parser produces nothing until restart
  a_idle_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_kind != pbtp_pkg::KIND_RESTART) &&
     ((phase_r == pbtp_pkg::PH_DONE) || (phase_r == pbtp_pkg::PH_ERROR)))
    |-> (res_n == 2'd0) && (phase_nxt == phase_r))
    else $error("result after finish or error");

endmodule

// ===== tb/sv/bitmap_parse_check.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bitmap_parse_check
// Watches both channels of the bitmap text parser. For every item taken on
// the input it works out the results that the parser owes, and compares each
// result taken on the output, field by field, with the oldest one still owed.
// ----------------------------------------------------------------------------
module bitmap_parse_check #(
  parameter int DIM_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  in_kind,
  input  logic [7:0]  in_byte_req,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [1:0]  out_result_kind,
  input  logic        out_pixel,
  input  logic [15:0] out_width,
  input  logic [15:0] out_height,
  input  logic [15:0] out_row,
  input  logic [15:0] out_column,
  input  logic [1:0]  out_error_code,
  input  logic        out_image_done,
  input  logic        out_last,
  input  logic        drain_check,
  output int          outstanding,
  output int          fail_count
);

  localparam longint DIM_MAX = (longint'(1) << DIM_BITS) - 1;

  // Parser state as predicted
  pbtp_pkg::phase_t  prs_phase;
  logic              comment_open;
  longint            num_acc;
  logic              have_digit;
  longint            img_width;
  longint            img_height;
  longint            row_at;
  longint            col_at;

  // Results of the item being parsed, then the results still owed
  pbtp_pkg::result_t step_res[2];
  int                step_n;
  pbtp_pkg::result_t owed_results[$];
  int                errs = 0;
  logic              drain_seen = 1'b0;

  function automatic logic is_blank(input logic [7:0] b);
    return (b == pbtp_pkg::CH_SPACE) || (b >= pbtp_pkg::CH_TAB && b <= pbtp_pkg::CH_CR);
  endfunction

  function automatic string describe(input pbtp_pkg::result_t r);
    return $sformatf("kind=%0d px=%0d w=%0d h=%0d row=%0d col=%0d err=%0d done=%0d last=%0d",
                     r.result_kind, r.pixel, r.width, r.height, r.row, r.column,
                     r.error_code, r.image_done, r.last);
  endfunction

  task automatic clear_parse();
    prs_phase    = pbtp_pkg::PH_MAGIC0;
    comment_open = 1'b0;
    num_acc      = 0;
    have_digit   = 1'b0;
    img_width    = 0;
    img_height   = 0;
    row_at       = 0;
    col_at       = 0;
  endtask

  task automatic post(input logic [1:0] kind, input logic px, input longint w,
                      input longint h, input longint r, input longint c,
                      input logic [1:0] code, input logic done);
    pbtp_pkg::result_t res;
    res             = '0;
    res.result_kind = kind;
    res.pixel       = px;
    res.width       = w[15:0];
    res.height      = h[15:0];
    res.row         = r[15:0];
    res.column      = c[15:0];
    res.error_code  = code;
    res.image_done  = done;
    step_res[step_n] = res;
    step_n++;
  endtask

  task automatic raise_error(input logic [1:0] code);
    post(pbtp_pkg::RES_ERROR, 1'b0, 0, 0, 0, 0, code, 1'b0);
    prs_phase = pbtp_pkg::PH_ERROR;
  endtask

  // Emit one pixel and advance the raster position
  task automatic take_pixel(input logic [7:0] b);
    longint r;
    longint c;
    logic   done;
    r    = row_at;
    c    = col_at;
    done = 1'b0;
    col_at++;
    if (col_at >= img_width) begin
      col_at = 0;
      row_at++;
      if (row_at >= img_height) begin
        done      = 1'b1;
        prs_phase = pbtp_pkg::PH_DONE;
      end
    end
    if (!done) prs_phase = pbtp_pkg::PH_PIXELS;
    post(pbtp_pkg::RES_PIXEL, b == pbtp_pkg::CH_ONE, 0, 0, r, c, '0, done);
  endtask

  task automatic parse_item(input logic [1:0] kind, input logic [7:0] b);
    logic eof;
    logic digit;
    logic empty;
    eof   = (kind == pbtp_pkg::KIND_EOF);
    digit = (b >= pbtp_pkg::CH_ZERO && b <= pbtp_pkg::CH_NINE);
    if (kind == pbtp_pkg::KIND_RESTART) begin
      clear_parse();
    end else if ((kind == pbtp_pkg::KIND_DATA || eof) && prs_phase != pbtp_pkg::PH_DONE &&
                 prs_phase != pbtp_pkg::PH_ERROR) begin
      case (prs_phase)
        pbtp_pkg::PH_MAGIC0: begin
          if (!eof && b == pbtp_pkg::CH_P) prs_phase = pbtp_pkg::PH_MAGIC1;
          else raise_error(pbtp_pkg::ERR_MAGIC);
        end
        pbtp_pkg::PH_MAGIC1: begin
          if (!eof && b == pbtp_pkg::CH_ONE) prs_phase = pbtp_pkg::PH_MAGIC2;
          else raise_error(pbtp_pkg::ERR_MAGIC);
        end
        pbtp_pkg::PH_MAGIC2: begin
          if (!eof && is_blank(b)) prs_phase = pbtp_pkg::PH_BLANK1;
          else raise_error(pbtp_pkg::ERR_MAGIC);
        end
        pbtp_pkg::PH_BLANK1, pbtp_pkg::PH_BLANK2: begin
          if (eof) begin
            raise_error(prs_phase == pbtp_pkg::PH_BLANK1 ? pbtp_pkg::ERR_HEADER
                                                         : pbtp_pkg::ERR_PREMATURE);
          end else if (comment_open) begin
            if (b == pbtp_pkg::CH_LF || b == pbtp_pkg::CH_CR) comment_open = 1'b0;
          end else if (is_blank(b)) begin
          end else if (b == pbtp_pkg::CH_HASH) begin
            comment_open = 1'b1;
          end else if (prs_phase == pbtp_pkg::PH_BLANK1) begin
            if (digit) begin
              num_acc    = b - pbtp_pkg::CH_ZERO;
              have_digit = 1'b1;
              prs_phase  = pbtp_pkg::PH_WIDTH;
            end else begin
              raise_error(pbtp_pkg::ERR_HEADER);
            end
          end else if (b == pbtp_pkg::CH_ZERO || b == pbtp_pkg::CH_ONE) begin
            take_pixel(b);
          end else begin
            raise_error(pbtp_pkg::ERR_DATA);
          end
        end
        pbtp_pkg::PH_WIDTH: begin
          if (eof) begin
            raise_error(pbtp_pkg::ERR_HEADER);
          end else if (digit) begin
            num_acc = num_acc * 10 + (b - pbtp_pkg::CH_ZERO);
            if (num_acc > DIM_MAX) raise_error(pbtp_pkg::ERR_HEADER);
          end else if (is_blank(b)) begin
            img_width  = num_acc;
            num_acc    = 0;
            have_digit = 1'b0;
            prs_phase  = pbtp_pkg::PH_HEIGHT;
          end else begin
            raise_error(pbtp_pkg::ERR_HEADER);
          end
        end
        pbtp_pkg::PH_HEIGHT: begin
          if (!have_digit) begin
            if (eof) begin
              raise_error(pbtp_pkg::ERR_HEADER);
            end else if (is_blank(b)) begin
            end else if (digit) begin
              num_acc    = b - pbtp_pkg::CH_ZERO;
              have_digit = 1'b1;
            end else begin
              raise_error(pbtp_pkg::ERR_HEADER);
            end
          end else if (!eof && digit) begin
            num_acc = num_acc * 10 + (b - pbtp_pkg::CH_ZERO);
            if (num_acc > DIM_MAX) raise_error(pbtp_pkg::ERR_HEADER);
          end else begin
            // Height complete: header goes out, then whatever ended the number
            img_height = num_acc;
            num_acc    = 0;
            have_digit = 1'b0;
            empty      = (img_width == 0 || img_height == 0);
            post(pbtp_pkg::RES_HEADER, 1'b0, img_width, img_height, 0, 0, '0, empty);
            if (empty) begin
              prs_phase = pbtp_pkg::PH_DONE;
            end else if (eof) begin
              raise_error(pbtp_pkg::ERR_PREMATURE);
            end else if (is_blank(b)) begin
              prs_phase = pbtp_pkg::PH_BLANK2;
            end else if (b == pbtp_pkg::CH_HASH) begin
              comment_open = 1'b1;
              prs_phase    = pbtp_pkg::PH_BLANK2;
            end else begin
              raise_error(pbtp_pkg::ERR_DATA);
            end
          end
        end
        pbtp_pkg::PH_PIXELS: begin
          if (eof) raise_error(pbtp_pkg::ERR_PREMATURE);
          else if (is_blank(b)) begin
          end else if (b == pbtp_pkg::CH_ZERO || b == pbtp_pkg::CH_ONE) take_pixel(b);
          else raise_error(pbtp_pkg::ERR_DATA);
        end
        default: ;
      endcase
    end
  endtask

  // Predict on input handshakes, compare on output handshakes
  always @(posedge clk) begin
    pbtp_pkg::result_t got;
    pbtp_pkg::result_t want;
    int                k;
    if (!rst_n) begin
      clear_parse();
      owed_results.delete();
      drain_seen = 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        step_n = 0;
        parse_item(in_kind, in_byte_req);
        if (step_n > 0) step_res[step_n - 1].last = 1'b1;
        for (k = 0; k < step_n; k++) owed_results.push_back(step_res[k]);
      end
      if (out_valid && !out_stall) begin
        got.result_kind = out_result_kind;
        got.pixel       = out_pixel;
        got.width       = out_width;
        got.height      = out_height;
        got.row         = out_row;
        got.column      = out_column;
        got.error_code  = out_error_code;
        got.image_done  = out_image_done;
        got.last        = out_last;
        if (owed_results.size() == 0) begin
          errs++;
          if (errs <= 10) $display("[%0t] result with none owed: %s", $realtime, describe(got));
        end else begin
          want = owed_results.pop_front();
          if (got.result_kind !== want.result_kind || got.pixel !== want.pixel ||
              got.width !== want.width || got.height !== want.height ||
              got.row !== want.row || got.column !== want.column ||
              got.error_code !== want.error_code || got.image_done !== want.image_done ||
              got.last !== want.last) begin
            errs++;
            if (errs <= 10) begin
              $display("[%0t] result mismatch", $realtime);
              $display("  expected %s", describe(want));
              $display("  actual   %s", describe(got));
            end
          end
        end
      end
      // Anything still owed at the end of the run is a failure
      if (drain_check && !drain_seen) begin
        drain_seen = 1'b1;
        if (owed_results.size() != 0) begin
          errs += owed_results.size();
          $display("[%0t] %0d results never arrived", $realtime, owed_results.size());
        end
      end
    end
    outstanding <= owed_results.size();
    fail_count  <= errs;
  end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the bitmap text parser with short directed items, then with random
// bitmap files (mostly well formed, some broken) and noise, under several
// idle and stall patterns including one long output hold-off.
// ----------------------------------------------------------------------------
module tb_top;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam logic [7:0] CH_MINUS    = 8'h2D;
  localparam logic [7:0] CH_PLUS     = 8'h2B;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_kind;
  logic [7:0]  in_byte_req;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  out_result_kind;
  logic        out_pixel;
  logic [15:0] out_width;
  logic [15:0] out_height;
  logic [15:0] out_row;
  logic [15:0] out_column;
  logic [1:0]  out_error_code;
  logic        out_image_done;
  logic        out_last;
  logic        drain_check;
  int          outstanding;
  int          fail_count;

  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;
  int hold_cycles  = 0;
  int items_sent   = 0;

  plain_bitmap_text_parser dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_kind        (in_kind),
    .in_byte_req    (in_byte_req),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_result_kind(out_result_kind),
    .out_pixel      (out_pixel),
    .out_width      (out_width),
    .out_height     (out_height),
    .out_row        (out_row),
    .out_column     (out_column),
    .out_error_code (out_error_code),
    .out_image_done (out_image_done),
    .out_last       (out_last)
  );

  bitmap_parse_check parse_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_kind        (in_kind),
    .in_byte_req    (in_byte_req),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_result_kind(out_result_kind),
    .out_pixel      (out_pixel),
    .out_width      (out_width),
    .out_height     (out_height),
    .out_row        (out_row),
    .out_column     (out_column),
    .out_error_code (out_error_code),
    .out_image_done (out_image_done),
    .out_last       (out_last),
    .drain_check    (drain_check),
    .outstanding    (outstanding),
    .fail_count     (fail_count)
  );

  // 12 ns clock
  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Hard stop if the run hangs
  initial begin
    #4_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // Result side: hold off for a counted stretch on request, else stall at random
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        out_stall <= 1'b1;
        hold_cycles--;
      end else begin
        out_stall <= ($urandom_range(0, 99) < rx_stall_pct);
      end
    end
  end

  // Offer one item, wait for it to be taken, then idle at random
  task automatic send_item(input logic [1:0] kind, input logic [7:0] b);
    int gap;
    in_valid    <= 1'b1;
    in_kind     <= kind;
    in_byte_req <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (kind != KIND_UNUSED) items_sent++;
    gap = 0;
    while (gap < 40 && $urandom_range(0, 99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_text(input string s);
    foreach (s[i]) send_item(pbtp_pkg::KIND_DATA, s[i]);
  endtask

  // Random whitespace: space, TAB, LF, VT, FF or CR
  function automatic logic [7:0] blank_char();
    int k;
    k = $urandom_range(0, 5);
    return (k == 5) ? pbtp_pkg::CH_SPACE : pbtp_pkg::CH_TAB + 8'(k);
  endfunction

  task automatic push_comment(ref logic [7:0] text[$]);
    logic [7:0] c;
    text.push_back(pbtp_pkg::CH_HASH);
    repeat ($urandom_range(0, 6)) begin
      c = 8'($urandom);
      text.push_back((c == pbtp_pkg::CH_LF || c == pbtp_pkg::CH_CR) ? pbtp_pkg::CH_P : c);
    end
    text.push_back($urandom_range(0, 1) ? pbtp_pkg::CH_LF : pbtp_pkg::CH_CR);
  endtask

  // Zero to two pieces of whitespace or comment
  task automatic push_gap(ref logic [7:0] text[$]);
    repeat ($urandom_range(0, 2)) begin
      if ($urandom_range(0, 2) == 0) push_comment(text);
      else text.push_back(blank_char());
    end
  endtask

  task automatic push_number(ref logic [7:0] text[$], input longint v);
    string s;
    s = $sformatf("%0d", v);
    foreach (s[i]) text.push_back(s[i]);
  endtask

  // Build one bitmap file, maybe break it, and feed it after a restart
  task automatic send_bitmap();
    logic [7:0] text[$];
    int w, h, dsel, flaw, npix, k, cut, hgt_end;
    dsel = $urandom_range(0, 19);
    flaw = $urandom_range(0, 99);
    w    = $urandom_range(1, 6);
    h    = $urandom_range(1, 5);
    case (dsel)
      0: begin w = 0; h = $urandom_range(0, 65535); end
      1: begin w = $urandom_range(1, 65535); h = 0; end
      2: begin w = $urandom_range(7, 40); h = 1; end
      3: begin w = 1; h = $urandom_range(6, 30); end
      default: ;
    endcase
    send_item(pbtp_pkg::KIND_RESTART, 8'($urandom));

    // Magic and header
    text.push_back(pbtp_pkg::CH_P);
    text.push_back(pbtp_pkg::CH_ONE);
    text.push_back(blank_char());
    push_gap(text);
    if (flaw < 4) text.push_back(flaw < 2 ? CH_MINUS : CH_PLUS);
    if ($urandom_range(0, 7) == 0) text.push_back(pbtp_pkg::CH_ZERO);
    push_number(text, (flaw >= 4 && flaw < 8) ?
                longint'($urandom_range(65536, 999999)) : longint'(w));
    repeat ($urandom_range(1, 2)) text.push_back(blank_char());
    if (flaw >= 8 && flaw < 10) text.push_back(CH_MINUS);
    push_number(text, (flaw >= 10 && flaw < 13) ?
                longint'($urandom_range(65536, 999999)) : longint'(h));
    hgt_end = text.size();
    if (flaw >= 38 && flaw < 42) text.push_back(pbtp_pkg::CH_P);
    else if ($urandom_range(0, 3) == 0) push_comment(text);
    else text.push_back(blank_char());
    push_gap(text);

    // Raster, with a stray comment mark after the first pixel for some files
    npix = w * h;
    for (k = 0; k < npix; k++) begin
      text.push_back($urandom_range(0, 1) ? pbtp_pkg::CH_ONE : pbtp_pkg::CH_ZERO);
      if (k == 0 && flaw >= 13 && flaw < 16) text.push_back(pbtp_pkg::CH_HASH);
      if ($urandom_range(0, 2) == 0) text.push_back(blank_char());
    end
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 3)) text.push_back(8'($urandom));
    end

    // Truncate or corrupt
    cut = -1;
    if (flaw >= 16 && flaw < 26) cut = $urandom_range(0, text.size() - 1);
    if (flaw >= 34 && flaw < 38) cut = hgt_end;
    if (cut >= 0) begin
      while (text.size() > cut) void'(text.pop_back());
    end
    if (flaw >= 26 && flaw < 34) text[$urandom_range(0, text.size() - 1)] = 8'($urandom);

    foreach (text[i]) send_item(pbtp_pkg::KIND_DATA, text[i]);
    if (cut >= 0 || $urandom_range(0, 1) == 1) send_item(pbtp_pkg::KIND_EOF, 8'($urandom));
  endtask

  initial begin
    int ph;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_kind     = pbtp_pkg::KIND_DATA;
    in_byte_req = 8'h00;
    drain_check = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: unused kind, bad first byte, end of input in the magic,
    // a width past the maximum, and the widest legal width with zero height
    send_item(KIND_UNUSED, 8'hFF);
    send_item(pbtp_pkg::KIND_DATA, 8'hFF);
    send_item(pbtp_pkg::KIND_RESTART, 8'h00);
    send_item(pbtp_pkg::KIND_EOF, 8'h00);
    send_item(pbtp_pkg::KIND_RESTART, 8'h00);
    send_text("P1 99999");
    send_item(pbtp_pkg::KIND_RESTART, 8'h00);
    send_text("P1\t65535 0\r");

    // Random files and noise under each idle pattern
    for (ph = 0; ph < 5; ph++) begin
      case (ph)
        1:       begin tx_idle_pct = 81; rx_stall_pct = 0;  end
        2:       begin tx_idle_pct = 0;  rx_stall_pct = 81; end
        3:       begin tx_idle_pct = 11; rx_stall_pct = 11; end
        default: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
      endcase
      if (ph == 4) hold_cycles = 400;
      while (items_sent < 25 + 265 * (ph + 1)) begin
        if ($urandom_range(0, 9) == 0) begin
          repeat ($urandom_range(1, 8)) send_item(2'($urandom_range(0, 3)), 8'($urandom));
        end else begin
          send_bitmap();
        end
      end
    end
    in_valid <= 1'b0;

    // Drain, let the pipeline settle, then check for leftovers
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    drain_check <= 1'b1;
    repeat (2) @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
